### design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants for the block reorder buffer: result kinds, field widths
// and the per-input result limit.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int SEQ_W   = 32;
  localparam int HDL_W   = 16;
  localparam int CNT_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = SEQ_W + HDL_W + CNT_W;

  // Most results one input may produce; pending deliveries carry over.
  localparam int RESULT_LIMIT = 16;
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_DELIVER = 2'd0;
  localparam kind_t KIND_DUP     = 2'd1;
  localparam kind_t KIND_BEYOND  = 2'd2;

endpackage

### design/block_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// block_reorder_buffer_unit
// Resequences blocks by sequence number through a window of WINDOW slots.
// ----------------------------------------------------------------------------
// One block is taken at a time. On acceptance it is classified (late, beyond
// the window, or in range) and in the insert state it is either stored in its
// slot or issues a discard/reject result. Each in-order delivery then passes
// through two steps: a read of the slot memory at the expected index and a
// load of the output register, which waits while the output is stalled. No
// new block is taken until the last result of the current one is loaded. The
// read step exists because the slot memory read is registered. At most 16
// results follow one input; held blocks left over are released after the
// next input. Slot valid bits clear at reset, so no clearing pass runs.
// ----------------------------------------------------------------------------
module block_reorder_buffer_unit
  import brb_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // seq_num[31:0], handle[47:32], byte_count[63:48]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // out_seq[31:0], out_handle[47:32], out_count[63:48]
  output logic [KIND_W-1:0]  out_tuser,  // kind[1:0]
  output logic               out_tlast
);

  localparam int IW = $clog2(WINDOW);
  localparam logic [IW:0]      WIN_S    = (IW+1)'(WINDOW);
  localparam logic [IW-1:0]    IDX_MAX  = IW'(WINDOW - 1);
  localparam logic [SEQ_W-1:0] WIN_SEQ  = SEQ_W'(WINDOW);
  localparam logic [RES_CNT_W-1:0] LIMIT_N = RES_CNT_W'(RESULT_LIMIT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SEQ_W-1:0]     exp_r, exp_nxt;
  logic [IW-1:0]        exp_idx_r, exp_idx_nxt;
  logic [WINDOW-1:0]    valid_r, valid_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;

  logic [SEQ_W-1:0]     seq_r;
  logic [HDL_W-1:0]     hdl_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 late_r, beyond_r;
  logic [IW-1:0]        off_r;

  logic                 out_valid_r;
  logic [TDATA_W-1:0]   out_data_r;
  kind_t                out_kind_r;
  logic                 out_last_r;

  logic                 out_load;
  logic [TDATA_W-1:0]   load_data;
  kind_t                load_kind;
  logic                 load_last;

  logic                 in_xfer;
  logic                 out_free;
  logic [SEQ_W:0]       diff;
  logic [IW:0]          slot_sum;
  logic [IW-1:0]        ins_idx;
  logic                 dup;
  logic                 echo;
  logic                 ram_wr, ram_rd;
  logic [HDL_W+CNT_W-1:0] ram_rd_data;
  logic                 limit_hit;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // borrow bit marks a late block
  assign diff = {1'b0, in_tdata[SEQ_W-1:0]} - {1'b0, exp_r};

  // slot index of the stored block: expected index plus offset, mod WINDOW
  assign slot_sum = {1'b0, exp_idx_r} + {1'b0, off_r};
  assign ins_idx  = (slot_sum >= WIN_S) ? IW'(slot_sum - WIN_S) : slot_sum[IW-1:0];
  assign dup      = valid_r[ins_idx];
  assign echo     = late_r || beyond_r || dup;
  assign limit_hit = (RES_CNT_W'(n_r + 1'b1) == LIMIT_N);

  brb_ram #(
    .WIDTH(HDL_W + CNT_W),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(ins_idx),
    .wr_data({cnt_r, hdl_r}),
    .rd_en  (ram_rd),
    .rd_addr(exp_idx_r),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    exp_nxt     = exp_r;
    exp_idx_nxt = exp_idx_r;
    valid_nxt   = valid_r;
    n_nxt       = n_r;
    ram_wr      = 1'b0;
    ram_rd      = 1'b0;
    out_load    = 1'b0;
    load_data   = {cnt_r, hdl_r, seq_r};
    load_kind   = KIND_DUP;
    load_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (echo) begin
          if (out_free) begin
            out_load  = 1'b1;
            // slot lookup is meaningless for late or out-of-window blocks
            load_kind = (beyond_r && !late_r) ? KIND_BEYOND : KIND_DUP;
            load_last = !valid_r[exp_idx_r] || (LIMIT_N == RES_CNT_W'(1));
            n_nxt     = RES_CNT_W'(1);
            state_nxt = load_last ? S_IDLE : S_READ;
          end
        end else begin
          ram_wr             = 1'b1;
          valid_nxt[ins_idx] = 1'b1;
          n_nxt              = '0;
          state_nxt = (valid_r[exp_idx_r] || (ins_idx == exp_idx_r)) ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        ram_rd    = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (out_free) begin
          out_load             = 1'b1;
          load_kind            = KIND_DELIVER;
          load_data            = {ram_rd_data, exp_r};
          valid_nxt[exp_idx_r] = 1'b0;
          exp_nxt              = exp_r + 1'b1;
          exp_idx_nxt          = (exp_idx_r == IDX_MAX) ? '0 : exp_idx_r + 1'b1;
          n_nxt                = RES_CNT_W'(n_r + 1'b1);
          load_last            = limit_hit || !valid_r[exp_idx_nxt];
          state_nxt            = load_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      exp_idx_r   <= '0;
      valid_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      exp_r     <= exp_nxt;
      exp_idx_r <= exp_idx_nxt;
      valid_r   <= valid_nxt;
      n_r       <= n_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seq_r    <= in_tdata[SEQ_W-1:0];
      hdl_r    <= in_tdata[SEQ_W+HDL_W-1:SEQ_W];
      cnt_r    <= in_tdata[TDATA_W-1:SEQ_W+HDL_W];
      late_r   <= diff[SEQ_W];
      beyond_r <= (diff[SEQ_W-1:0] >= WIN_SEQ);
      off_r    <= diff[IW-1:0];
    end
    if (out_load) begin
      out_data_r <= load_data;
      out_kind_r <= load_kind;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

### design/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks for the block reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brb_checker
  import brb_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]  out_tuser,
  input logic               out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // one block at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

  // more results of the current block are pending
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready before the last result was issued");

  // a discard or reject never follows a delivery of the same input
  a_deliver_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_DELIVER && !out_tlast
      |=> !(out_tvalid && out_tuser != KIND_DELIVER))
    else $error("non-delivery result inside a delivery run");

endmodule

bind block_reorder_buffer_unit brb_checker u_brb_checker (.*);
